// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the homogeneous point transform RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/hpt_pkg.sv =====
// Package for the homogeneous point transform: opcodes, states and the
// command/status structs between controller and datapath. No dependencies.
package hpt_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_DIR   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic       capture;    // latch the input item
    logic       load;       // write one matrix element
    logic       mac_step;   // one multiply-accumulate step
    logic       mac_clear;  // clear accumulators
    logic       div_start;  // start dividing the current component
    logic [1:0] comp;       // component under division
    logic       out_load;   // move results to output register
  } hpt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mac_done;
    logic div_done;
  } hpt_sts_t;

endpackage

// ===== hdl/hpt_div.sv =====
// Restoring divider for the point transform: (num * 2^FRAC) / den, truncated
// toward zero, saturated to the word range. Depends on hpt_pkg.
`include "assert_macros.svh"
module hpt_div #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int SUM_W      = 72
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [SUM_W-1:0]      num,
  input  logic signed [SUM_W-1:0]      den,
  output logic                         done,
  output logic signed [WORD_WIDTH-1:0] quo,
  output logic                         err
);
  import hpt_pkg::*;

  localparam int STEPS = SUM_W + FRAC_BITS;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int QW    = WORD_WIDTH + 1;

  logic [SUM_W-1:0]     n_r, n_nxt;
  logic [SUM_W-1:0]     d_r, d_nxt;
  logic [SUM_W:0]       rem_r, rem_nxt;
  logic [QW-1:0]        q_r, q_nxt;
  logic [QW-1:0]        lim_r, lim_nxt;
  logic                 neg_r, neg_nxt;
  logic                 busy_r, busy_nxt;
  logic                 sat_r, sat_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic signed [WORD_WIDTH-1:0] quo_r, quo_nxt;
  logic                 err_r, err_nxt;

  logic [SUM_W:0]       shr;
  logic                 bitin;
  logic [QW-1:0]        qs;
  logic [SUM_W-1:0]     an, ad;
  logic [QW-1:0]        wmax;

  assign wmax = {2'b00, {(WORD_WIDTH-1){1'b1}}};
  assign an   = num[SUM_W-1] ? (~num + 1'b1) : num;
  assign ad   = den[SUM_W-1] ? (~den + 1'b1) : den;

  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    lim_nxt  = lim_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    err_nxt  = err_r;
    bitin    = n_r[SUM_W-1];
    shr      = {rem_r[SUM_W-1:0], bitin};
    qs       = {q_r[QW-2:0], 1'b0};
    if (start) begin
      neg_nxt  = num[SUM_W-1] ^ den[SUM_W-1];
      lim_nxt  = wmax + QW'(num[SUM_W-1] ^ den[SUM_W-1]);
      n_nxt    = an;
      d_nxt    = ad;
      rem_nxt  = '0;
      q_nxt    = '0;
      sat_nxt  = 1'b0;
      cnt_nxt  = '0;
      if (den == '0) begin
        done_nxt = 1'b1;
        err_nxt  = 1'b1;
        if (num == '0)            quo_nxt = '0;
        else if (num[SUM_W-1])    quo_nxt = {1'b1, {(WORD_WIDTH-1){1'b0}}};
        else                      quo_nxt = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end else begin
        busy_nxt = 1'b1;
        err_nxt  = 1'b0;
      end
    end else if (busy_r) begin
      // One quotient bit per cycle; numerator bits, then FRAC zero bits.
      if (q_r > (lim_r >> 1)) begin
        sat_nxt  = 1'b1;
        q_nxt    = lim_r;
        busy_nxt = 1'b0;
      end else begin
        if (shr >= {1'b0, d_r}) begin
          rem_nxt = shr - {1'b0, d_r};
          q_nxt   = qs | QW'(1);
        end else begin
          rem_nxt = shr;
          q_nxt   = qs;
        end
        n_nxt   = {n_r[SUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (q_nxt > lim_r) begin
          sat_nxt  = 1'b1;
          q_nxt    = lim_r;
          busy_nxt = 1'b0;
        end else if (cnt_r == CW'(STEPS - 1)) begin
          busy_nxt = 1'b0;
        end
      end
      if (!busy_nxt) begin
        done_nxt = 1'b1;
        err_nxt  = sat_nxt;
        quo_nxt  = neg_r ? WORD_WIDTH'(~q_nxt + 1'b1) : WORD_WIDTH'(q_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    lim_r <= lim_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    err_r <= err_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign err  = err_r;

  `ASSERT_NEVER(a_no_start_busy, clk, rst_n, start && busy_r, "divider started while busy")
  `ASSERT_NEVER(a_done_busy, clk, rst_n, done_r && busy_r, "divider done while busy")
  `ASSERT_IMPL(a_q_in_limit, clk, rst_n, busy_r |-> (q_r <= lim_r), "quotient over limit")
endmodule

// ===== hdl/hpt_datapath.sv =====
// Datapath of the point transform: matrix store, input registers, one shared
// multiplier with column accumulators, divider and output register. Uses hpt_pkg.
`include "assert_macros.svh"
module hpt_datapath #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hpt_pkg::hpt_cmd_t            cmd,
  output hpt_pkg::hpt_sts_t            sts,
  input  logic [1:0]                   in_operation,
  input  logic [1:0]                   in_row,
  input  logic [1:0]                   in_col,
  input  logic signed [31:0]           in_coef,
  input  logic signed [31:0]           in_in_x,
  input  logic signed [31:0]           in_in_y,
  input  logic signed [31:0]           in_in_z,
  output logic signed [WORD_WIDTH-1:0] res_x,
  output logic signed [WORD_WIDTH-1:0] res_y,
  output logic signed [WORD_WIDTH-1:0] res_z,
  output logic                         res_err
);
  import hpt_pkg::*;

  // Sum of three 64-bit products, shifted, plus a 32-bit element.
  localparam int SUM_W = 72;

  logic signed [31:0] mat_r [16];
  logic signed [31:0] vec_r [3];
  logic               point_r;
  logic [3:0]         step_r;   // {k, col}
  logic signed [63:0] prod_r;
  logic               prod_v_r;
  logic [3:0]         pstep_r;
  logic signed [SUM_W-1:0] hi_r [4];
  logic [FRAC_BITS+1:0]    lo_r [4];
  logic                    fin_r;
  logic signed [SUM_W-1:0] sum_r [4];
  logic signed [WORD_WIDTH-1:0] rx_r [3];
  logic               err_r;
  logic               mac_done_r;

  logic [1:0]               pc;
  logic signed [SUM_W-1:0]  num_sel;
  logic                     dv_done;
  logic signed [WORD_WIDTH-1:0] dv_q;
  logic                     dv_err;
  logic signed [SUM_W-1:0]  wmax, wmin;
  logic signed [SUM_W-1:0]  sat_v [3];
  logic                     sat_e [3];

  assign pc = pstep_r[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
      prod_v_r   <= 1'b0;
      fin_r      <= 1'b0;
      mac_done_r <= 1'b0;
      step_r     <= '0;
    end else begin
      if (cmd.load) mat_r[{in_row, in_col}] <= in_coef;
      if (cmd.mac_clear) step_r <= '0;
      else if (cmd.mac_step) step_r <= step_r + 1'b1;
      prod_v_r   <= cmd.mac_step;
      fin_r      <= prod_v_r && (pstep_r == 4'hb);
      mac_done_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vec_r[0] <= in_in_x;
      vec_r[1] <= in_in_y;
      vec_r[2] <= in_in_z;
      point_r  <= (in_operation == OP_POINT);
    end
    prod_r  <= 64'(vec_r[step_r[3:2]]) * 64'(mat_r[{step_r[3:2], step_r[1:0]}]);
    pstep_r <= step_r;
    if (cmd.mac_clear) begin
      for (int i = 0; i < 4; i++) begin
        hi_r[i] <= '0;
        lo_r[i] <= '0;
      end
    end else if (prod_v_r) begin
      hi_r[pc] <= hi_r[pc] + SUM_W'(prod_r >>> FRAC_BITS);
      lo_r[pc] <= lo_r[pc] + (FRAC_BITS+2)'(prod_r[FRAC_BITS-1:0]);
    end
    if (fin_r) begin
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= hi_r[i] + SUM_W'(lo_r[i] >> FRAC_BITS)
                  + (point_r ? SUM_W'(mat_r[{2'd3, 2'(i)}]) : '0);
      end
    end
  end

  assign num_sel = (cmd.comp == 2'd0) ? sum_r[0] :
                   (cmd.comp == 2'd1) ? sum_r[1] : sum_r[2];

  hpt_div #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (num_sel),
    .den  (sum_r[3]),
    .done (dv_done),
    .quo  (dv_q),
    .err  (dv_err)
  );

  assign wmax = SUM_W'({1'b0, {(WORD_WIDTH-1){1'b1}}});
  assign wmin = ~wmax;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_e[i] = 1'b0;
      sat_v[i] = sum_r[i];
      if (sum_r[i] > wmax) begin
        sat_v[i] = wmax;
        sat_e[i] = 1'b1;
      end else if (sum_r[i] < wmin) begin
        sat_v[i] = wmin;
        sat_e[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) err_r <= 1'b0;
    if (dv_done) begin
      rx_r[cmd.comp] <= dv_q;
      if (dv_err) err_r <= 1'b1;
    end
    if (cmd.out_load && !point_r) begin
      for (int i = 0; i < 3; i++) rx_r[i] <= WORD_WIDTH'(sat_v[i]);
      err_r <= sat_e[0] | sat_e[1] | sat_e[2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_x   <= point_r ? rx_r[0] : WORD_WIDTH'(sat_v[0]);
      res_y   <= point_r ? rx_r[1] : WORD_WIDTH'(sat_v[1]);
      res_z   <= point_r ? rx_r[2] : WORD_WIDTH'(sat_v[2]);
      res_err <= point_r ? err_r : (sat_e[0] | sat_e[1] | sat_e[2]);
    end
  end

  assign sts.mac_done = mac_done_r;
  assign sts.div_done = dv_done;

  `ASSERT_NEVER(a_step_and_clear, clk, rst_n, cmd.mac_step && cmd.mac_clear, "mac step during clear")
  `ASSERT_NEVER(a_load_during_mac, clk, rst_n, cmd.load && cmd.mac_step, "matrix write during mac")
endmodule

// ===== hdl/hpt_ctrl.sv =====
// Controller of the point transform: handshakes and sequencing of the
// multiply-accumulate and divide phases. Uses hpt_pkg.
`include "assert_macros.svh"
module hpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  output logic              out_valid,
  input  logic              out_ready,
  output hpt_pkg::hpt_cmd_t cmd,
  input  hpt_pkg::hpt_sts_t sts
);
  import hpt_pkg::*;

  state_t     state_r, state_nxt;
  logic       point_r, point_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [3:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  // Idle may take a new item as long as the output register is free or drains.
  assign in_ready = (state_r == ST_IDLE) && (!ov_r || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    point_nxt = point_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (in_operation == OP_POINT || in_operation == OP_DIR)) begin
          state_nxt = ST_MAC;
          point_nxt = (in_operation == OP_POINT);
          step_nxt  = '0;
        end
      end
      ST_MAC: begin
        if (step_r != 4'hf) step_nxt = step_r + 1'b1;
        if (sts.mac_done) begin
          comp_nxt  = '0;
          state_nxt = point_r ? ST_DIV_START : ST_OUT;
        end
      end
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (comp_r == 2'd2) state_nxt = ST_OUT;
          else begin
            comp_nxt  = comp_r + 1'b1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.comp      = comp_r;
    cmd.capture   = acc;
    cmd.load      = acc && (in_operation == OP_LOAD);
    cmd.mac_clear = acc;
    ov_nxt        = ov_r && !out_ready;
    unique case (state_r)
      ST_MAC:       cmd.mac_step = (step_r < 4'd12);
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      point_r <= 1'b0;
      comp_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      point_r <= point_nxt;
      comp_r  <= comp_nxt;
      step_r  <= step_nxt;
    end
  end

  assign out_valid = ov_r;

  `ASSERT_IMPL(a_out_hold, clk, rst_n, (ov_r && !out_ready) |=> ov_r, "result dropped")
  `ASSERT_NEVER(a_ready_busy, clk, rst_n, in_ready && (state_r != ST_IDLE), "ready while busy")
  `ASSERT_IMPL(a_div_comp, clk, rst_n, cmd.div_start |-> (comp_r != 2'd3), "bad component")
endmodule

// ===== hdl/homogeneous_point_transform.sv =====
// Top level of the homogeneous 4x4 point transform.
// Depends on hpt_pkg, hpt_ctrl, hpt_datapath and hpt_div.
//
//   channel  direction  ports
//   in       input      in_valid/in_ready, operation, row, col, coef, x, y, z
//   out      output     out_valid/out_ready, out_x, out_y, out_z, div_error
//
// A load item or an unused code gives no result. A direction item runs twelve
// products through one shared 32x32 multiplier. A point item adds three
// divisions in the bit-serial divider. A synchronous reset clears the matrix
// and control; the output register holds a result while out_ready is low and
// the next item waits.
module homogeneous_point_transform #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [1:0]                   in_row,
  input  logic [1:0]                   in_col,
  input  logic signed [31:0]           in_coef,
  input  logic signed [31:0]           in_in_x,
  input  logic signed [31:0]           in_in_y,
  input  logic signed [31:0]           in_in_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] out_x,
  output logic signed [WORD_WIDTH-1:0] out_y,
  output logic signed [WORD_WIDTH-1:0] out_z,
  output logic                         out_div_error
);
  import hpt_pkg::*;

  hpt_cmd_t cmd;
  hpt_sts_t sts;

  hpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  hpt_datapath #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_operation(in_operation),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_coef     (in_coef),
    .in_in_x     (in_in_x),
    .in_in_y     (in_in_y),
    .in_in_z     (in_in_z),
    .res_x       (out_x),
    .res_y       (out_y),
    .res_z       (out_z),
    .res_err     (out_div_error)
  );
endmodule
